@@ hdl/i2c_mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types and constants for the front queue and the bus sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2c_mbe_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int PHASE_W       = 16;
   localparam int BYTE_W        = 8;
   localparam int CMD_W         = 3;

   typedef enum logic [CMD_W-1:0] {
      MODE_IDLE  = 3'd0,
      MODE_START = 3'd1,
      MODE_STOP  = 3'd2,
      MODE_WRITE = 3'd3,
      MODE_READ  = 3'd4
   } mode_type;

   // classified tick as held in the queue
   typedef struct packed {
      mode_type          cmd;
      logic              has_cmd;
      logic [BYTE_W-1:0] write_data;
      logic              ack_level;
      logic              sda_in;
   } item_type;

   typedef struct packed {
      logic              scl_level;
      logic              sda_level;
      logic              busy_res;
      logic              done_res;
      logic [BYTE_W-1:0] read_data;
      logic              ack_received;
      logic              rejected;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/i2c_mbe_if.sv @@
// ----------------------------------------------------------------------------
// I2C master byte engine channels
// Valid/ready channels for tick items, result items and the phase register.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2c_mbe_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [7:0] write_data;
   logic       ack_level;
   logic       sda_in;

   modport source (output valid, command, write_data, ack_level, sda_in, input ready);
   modport sink   (input valid, command, write_data, ack_level, sda_in, output ready);
endinterface

interface i2c_mbe_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic       ack_received;
   logic       rejected;

   modport source (output valid, scl_level, sda_level, busy_res, done_res, read_data,
                   ack_received, rejected, input ready);
   modport sink   (input valid, scl_level, sda_level, busy_res, done_res, read_data,
                   ack_received, rejected, output ready);
endinterface

interface i2c_mbe_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] phase_ticks;

   modport source (output valid, phase_ticks, input ready);
   modport sink   (input valid, phase_ticks, output ready);
endinterface

`default_nettype wire

@@ hdl/i2c_mbe_front.sv @@
// ----------------------------------------------------------------------------
// I2C master byte engine front
// Accepts tick items, decodes the command and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_mbe_front
   import i2c_mbe_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   i2c_mbe_req_if.sink req_chan,
   output item_type    q_item,
   output logic        q_valid,
   input  wire logic   q_pop
);

   item_type    mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff,  count_in;
   item_type    dec_item;
   logic        push;

   always_comb begin
      dec_item.has_cmd    = (req_chan.command != 3'd0);
      dec_item.write_data = req_chan.write_data;
      dec_item.ack_level  = req_chan.ack_level;
      dec_item.sda_in     = req_chan.sda_in;
      unique case (req_chan.command)
         3'd1:    dec_item.cmd = MODE_START;
         3'd2:    dec_item.cmd = MODE_STOP;
         3'd3:    dec_item.cmd = MODE_WRITE;
         3'd4:    dec_item.cmd = MODE_READ;
         default: dec_item.cmd = MODE_IDLE;
      endcase
   end

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign q_valid        = (count_ff != 2'd0);
   assign q_item         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= dec_item;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) && !q_pop |=> count_ff == 2'd2)
      else $error("full queue lost an entry");

endmodule

`default_nettype wire

@@ hdl/i2c_mbe_back.sv @@
// ----------------------------------------------------------------------------
// I2C master byte engine back
// Steps the SCL/SDA phase sequencer once per queued tick, drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_mbe_back
   import i2c_mbe_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   i2c_mbe_csr_if.sink csr_chan,
   i2c_mbe_rsp_if.source rsp_chan,
   input  item_type    q_item,
   input  wire logic   q_valid,
   output logic        q_pop
);

   logic [PHASE_W-1:0] phase_ticks_ff;
   mode_type           mode_ff,      mode_in;
   logic [2:0]         phase_ff,     phase_in;
   logic [3:0]         bit_cnt_ff,   bit_cnt_in;
   logic [BYTE_W-1:0]  shift_ff,     shift_in;
   logic [PHASE_W-1:0] tick_ff,      tick_in;
   logic               scl_ff,       scl_in;
   logic               sda_ff,       sda_in;
   logic               ack_flag_ff,  ack_flag_in;
   logic               nak_ff,       nak_in;
   logic [BYTE_W-1:0]  read_res_ff,  read_res_in;
   rsp_type            rsp_ff,       rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PHASE_W-1:0] plen;
   logic [3:0]         bit_inc;
   logic               fin;
   logic               rej;
   logic               done;

   assign csr_chan.ready = 1'b1;
   assign plen    = (phase_ticks_ff == '0) ? PHASE_W'(1) : phase_ticks_ff;
   assign bit_inc = bit_cnt_ff + 4'd1;
   assign q_pop   = q_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      mode_in     = mode_ff;
      phase_in    = phase_ff;
      bit_cnt_in  = bit_cnt_ff;
      shift_in    = shift_ff;
      tick_in     = tick_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      ack_flag_in = ack_flag_ff;
      nak_in      = nak_ff;
      read_res_in = read_res_ff;
      fin         = 1'b0;
      rej         = 1'b0;
      done        = 1'b0;
      if (q_pop) begin
         if (mode_ff == MODE_IDLE) begin
            if (q_item.cmd != MODE_IDLE) begin
               mode_in    = q_item.cmd;
               bit_cnt_in = 4'd0;
               phase_in   = 3'd0;
               tick_in    = plen;
               unique case (q_item.cmd)
                  MODE_WRITE: begin
                     shift_in = q_item.write_data;
                     sda_in   = q_item.write_data[BITS_PER_BYTE-1];
                  end
                  MODE_READ: begin
                     shift_in = '0;
                     nak_in   = q_item.ack_level;
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                  end
                  default: begin
                     scl_in = 1'b0;
                  end
               endcase
            end
         end else begin
            rej = q_item.has_cmd;
            if (tick_ff <= PHASE_W'(1)) begin
               tick_in = '0;
               unique case (mode_ff)
                  MODE_START: begin
                     unique case (phase_ff)
                        3'd0: begin sda_in = 1'b1; phase_in = 3'd1; tick_in = plen; end
                        3'd1: begin scl_in = 1'b1; phase_in = 3'd2; tick_in = plen; end
                        3'd2: begin sda_in = 1'b0; phase_in = 3'd3; tick_in = plen; end
                        default: begin scl_in = 1'b0; fin = 1'b1; end
                     endcase
                  end
                  MODE_STOP: begin
                     unique case (phase_ff)
                        3'd0: begin sda_in = 1'b0; phase_in = 3'd1; tick_in = plen; end
                        3'd1: begin scl_in = 1'b1; phase_in = 3'd2; tick_in = plen; end
                        default: begin sda_in = 1'b1; fin = 1'b1; end
                     endcase
                  end
                  MODE_WRITE: begin
                     unique case (phase_ff)
                        3'd0: begin scl_in = 1'b1; phase_in = 3'd1; tick_in = plen; end
                        3'd1: begin
                           scl_in     = 1'b0;
                           bit_cnt_in = bit_inc;
                           tick_in    = plen;
                           if (bit_inc < 4'(BITS_PER_BYTE)) begin
                              sda_in   = shift_ff[~bit_inc[2:0]];
                              phase_in = 3'd0;
                           end else begin
                              phase_in = 3'd2;
                           end
                        end
                        3'd2: begin sda_in = 1'b1; phase_in = 3'd3; tick_in = plen; end
                        3'd3: begin scl_in = 1'b1; phase_in = 3'd4; tick_in = plen; end
                        default: begin
                           ack_flag_in = ~q_item.sda_in;
                           scl_in      = 1'b0;
                           fin         = 1'b1;
                        end
                     endcase
                  end
                  MODE_READ: begin
                     unique case (phase_ff)
                        3'd0: begin scl_in = 1'b1; phase_in = 3'd1; tick_in = plen; end
                        3'd1: begin
                           shift_in   = {shift_ff[BYTE_W-2:0], q_item.sda_in};
                           scl_in     = 1'b0;
                           bit_cnt_in = bit_inc;
                           tick_in    = plen;
                           phase_in   = (bit_inc < 4'(BITS_PER_BYTE)) ? 3'd0 : 3'd2;
                        end
                        3'd2: begin sda_in = nak_ff; phase_in = 3'd3; tick_in = plen; end
                        3'd3: begin scl_in = 1'b1; phase_in = 3'd4; tick_in = plen; end
                        default: begin
                           scl_in      = 1'b0;
                           read_res_in = shift_ff;
                           fin         = 1'b1;
                        end
                     endcase
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
               if (fin) begin
                  mode_in  = MODE_IDLE;
                  phase_in = 3'd0;
                  done     = 1'b1;
               end
            end else begin
               tick_in = tick_ff - PHASE_W'(1);
            end
         end
      end

      rsp_in.scl_level    = scl_in;
      rsp_in.sda_level    = sda_in;
      rsp_in.busy_res     = (mode_in != MODE_IDLE);
      rsp_in.done_res     = done;
      rsp_in.read_data    = read_res_in;
      rsp_in.ack_received = ack_flag_in;
      rsp_in.rejected     = rej;

      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_W'(4);
         mode_ff        <= MODE_IDLE;
         phase_ff       <= 3'd0;
         bit_cnt_ff     <= 4'd0;
         shift_ff       <= '0;
         tick_ff        <= '0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         ack_flag_ff    <= 1'b0;
         nak_ff         <= 1'b1;
         read_res_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            phase_ticks_ff <= csr_chan.phase_ticks;
         end
         mode_ff        <= mode_in;
         phase_ff       <= phase_in;
         bit_cnt_ff     <= bit_cnt_in;
         shift_ff       <= shift_in;
         tick_ff        <= tick_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in;
         ack_flag_ff    <= ack_flag_in;
         nak_ff         <= nak_in;
         read_res_ff    <= read_res_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.scl_level    = rsp_ff.scl_level;
   assign rsp_chan.sda_level    = rsp_ff.sda_level;
   assign rsp_chan.busy_res     = rsp_ff.busy_res;
   assign rsp_chan.done_res     = rsp_ff.done_res;
   assign rsp_chan.read_data    = rsp_ff.read_data;
   assign rsp_chan.ack_received = rsp_ff.ack_received;
   assign rsp_chan.rejected     = rsp_ff.rejected;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.busy_res)
      else $error("done reported while still busy");

   a_idle_phase_zero: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> phase_ff == 3'd0)
      else $error("idle with nonzero phase");

   a_bit_cnt_range: assert property (@(posedge clock) disable iff (reset)
      bit_cnt_ff <= 4'(BITS_PER_BYTE))
      else $error("bit counter past byte length");

   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_item.has_cmd && (mode_ff != MODE_IDLE) |=> rsp_ff.rejected)
      else $error("command during sequence not flagged");

endmodule

`default_nettype wire

@@ hdl/i2c_master_byte_engine_unit.sv @@
// ----------------------------------------------------------------------------
// I2C master byte engine
// Bit-level I2C master: start, stop, write byte and read byte sequences.
// ----------------------------------------------------------------------------
//  channel    dir  payload                                   transfer
//  req_chan   in   command, write_data, ack_level, sda_in    valid & ready
//  rsp_chan   out  scl/sda levels, busy, done, data, acks    valid & ready
//  csr_chan   in   phase_ticks                               valid & ready
//
//  One tick transfer in, one result transfer out; sustained rate one per cycle while rsp is ready.
//  Registered path: queue entry, then the sequencer step into the output
//  register. While rsp stalls the two-entry front queue takes two more
//  transfers, then drops req ready until the result is taken.
//  Synchronous reset clears the queue, the sequencer and phase_ticks to 4.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine_unit
   import i2c_mbe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   i2c_mbe_req_if.sink   req_chan,
   i2c_mbe_rsp_if.source rsp_chan,
   i2c_mbe_csr_if.sink   csr_chan
);

   item_type q_item;
   logic     q_valid;
   logic     q_pop;

   i2c_mbe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_item   (q_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop)
   );

   i2c_mbe_back u_back (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .rsp_chan (rsp_chan),
      .q_item   (q_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop)
   );

endmodule

`default_nettype wire
